// ----- hdl/cigar_breakpoint_scanner_unit_macros.svh -----
// Assertion macros shared by the breakpoint scanner RTL.
`ifndef CIGAR_BREAKPOINT_SCANNER_UNIT_MACROS_SVH
`define CIGAR_BREAKPOINT_SCANNER_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Condition that must never be true outside reset.
`define CBS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

// ----- hdl/cbs_pkg.sv -----
// Shared types, constants and helpers of the CIGAR breakpoint scanner.
package cbs_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned LenW   = 28;
  localparam int unsigned RidW   = 31;
  localparam int unsigned CfgW   = 28;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned NumEv  = 4;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [PosW-1:0] PosMax = '1;

  localparam logic [CfgW-1:0] MinDelReset  = CfgW'(100);
  localparam logic [CfgW-1:0] MinClipReset = CfgW'(20);

  typedef enum logic [3:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_H  = 4'd5,
    OP_P  = 4'd6,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    EV_DEL   = 2'd0,
    EV_LCLIP = 2'd1,
    EV_RCLIP = 2'd2,
    EV_SUM   = 2'd3
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INDEL_EN = 2'd0,
    CFG_CLIP_EN  = 2'd1,
    CFG_MIN_DEL  = 2'd2,
    CFG_MIN_CLIP = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]      op_code;
    logic [LenW-1:0] op_length;
    logic            first_op;
    logic            last_op;
    logic [RidW-1:0] reference_id;
    logic [PosW-1:0] align_start;
    logic            reverse_strand;
    logic [LenW-1:0] read_length;
  } in_req_t;

  typedef struct packed {
    event_e          event_kind;
    logic [PosW-1:0] left_position;
    logic [PosW-1:0] right_position;
    logic [RidW-1:0] ref_index;
    logic            strand_reverse;
    logic [LenW-1:0] clip_start;
    logic [LenW-1:0] clip_length;
    logic [PosW-1:0] reference_end;
    logic [PosW-1:0] query_start;
    logic [PosW-1:0] query_stop;
    logic [PosW-1:0] query_total;
    logic            last_result;
  } out_rsp_t;

  // One classified op: which results it owes plus everything to build them.
  typedef struct packed {
    logic [NumEv-1:0] ev;
    logic [RidW-1:0]  rid;
    logic             strand;
    logic [PosW-1:0]  start;
    logic [PosW-1:0]  ref_before;
    logic [PosW-1:0]  ref_end;
    logic [LenW-1:0]  lclip_len;
    logic [LenW-1:0]  rclip_start;
    logic [LenW-1:0]  rclip_len;
    logic [PosW-1:0]  q_begin;
    logic [PosW-1:0]  q_end;
    logic [PosW-1:0]  q_size;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
                                               input logic [LenW-1:0] b);
    logic [PosW:0] sum;
    sum = {1'b0, a} + (PosW+1)'(b);
    return sum[PosW] ? PosMax : sum[PosW-1:0];
  endfunction

endpackage

// ----- hdl/cbs_front.sv -----
// Front end: config registers, record accumulators and op classification.
module cbs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cbs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cbs_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cbs_pkg::in_req_t             in_req_i,
  input  cbs_pkg::q_stat_t             q_stat_i,
  output logic                         push_o,
  output cbs_pkg::job_t                job_o
);

  logic                        indel_en_q, clip_en_q;
  logic [cbs_pkg::CfgW-1:0]    min_del_q, min_clip_q;
  logic [cbs_pkg::PosW-1:0]    re_q, qb_q, qe_q, qs_q;
  logic [cbs_pkg::PosW-1:0]    re0, qb0, qe0, qs0;
  logic [cbs_pkg::PosW-1:0]    re_d, qb_d, qe_d, qs_d;
  logic [cbs_pkg::PosW-1:0]    len_w;
  logic [cbs_pkg::LenW-1:0]    len, rlen;
  logic                        undet, is_s, is_del, clip_hit, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      indel_en_q <= 1'b1;
      clip_en_q  <= 1'b1;
      min_del_q  <= cbs_pkg::MinDelReset;
      min_clip_q <= cbs_pkg::MinClipReset;
    end else if (cfg_we_i) begin
      unique case (cbs_pkg::cfg_idx_e'(cfg_index_i))
        cbs_pkg::CFG_INDEL_EN: indel_en_q <= cfg_wdata_i[0];
        cbs_pkg::CFG_CLIP_EN:  clip_en_q  <= cfg_wdata_i[0];
        cbs_pkg::CFG_MIN_DEL:  min_del_q  <= cfg_wdata_i;
        cbs_pkg::CFG_MIN_CLIP: min_clip_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign len   = in_req_i.op_length;
  assign rlen  = in_req_i.read_length;
  assign len_w = cbs_pkg::PosW'(len);

  // a first op restarts the record before the op itself is applied
  always_comb begin
    re0 = in_req_i.first_op ? in_req_i.align_start : re_q;
    qb0 = in_req_i.first_op ? cbs_pkg::PosMax : qb_q;
    qe0 = in_req_i.first_op ? '0 : qe_q;
    qs0 = in_req_i.first_op ? '0 : qs_q;
  end

  assign undet = (qb0 == cbs_pkg::PosMax);

  always_comb begin
    re_d   = re0;
    qb_d   = qb0;
    qe_d   = qe0;
    qs_d   = qs0;
    is_s   = 1'b0;
    is_del = 1'b0;
    unique case (cbs_pkg::op_e'(in_req_i.op_code))
      cbs_pkg::OP_M, cbs_pkg::OP_EQ, cbs_pkg::OP_X: begin
        re_d = cbs_pkg::sat_add(re0, len);
        if (undet) begin
          qb_d = '0;
          qe_d = len_w;
        end else begin
          qe_d = cbs_pkg::sat_add(qe0, len);
        end
        qs_d = cbs_pkg::sat_add(qs0, len);
      end
      cbs_pkg::OP_S, cbs_pkg::OP_H: begin
        is_s = (cbs_pkg::op_e'(in_req_i.op_code) == cbs_pkg::OP_S);
        if (undet) begin
          qb_d = len_w;
          qe_d = len_w;
        end
        qs_d = cbs_pkg::sat_add(qs0, len);
      end
      cbs_pkg::OP_I, cbs_pkg::OP_P: begin
        qe_d = cbs_pkg::sat_add(qe0, len);
        if (undet) qb_d = '0;
        qs_d = cbs_pkg::sat_add(qs0, len);
      end
      cbs_pkg::OP_D, cbs_pkg::OP_N: begin
        is_del = 1'b1;
        if (undet) begin
          qb_d = len_w;
          qe_d = len_w;
        end
        re_d = cbs_pkg::sat_add(re0, len);
      end
      default: ;  // undefined codes leave the record untouched
    endcase
  end

  assign clip_hit = is_s & clip_en_q & (len >= min_clip_q);

  always_comb begin
    job_o = '0;
    job_o.ev[cbs_pkg::EV_DEL]   = is_del & indel_en_q & (len >= min_del_q);
    job_o.ev[cbs_pkg::EV_LCLIP] = clip_hit & in_req_i.first_op;
    job_o.ev[cbs_pkg::EV_RCLIP] = clip_hit & in_req_i.last_op;
    job_o.ev[cbs_pkg::EV_SUM]   = in_req_i.last_op;
    job_o.rid         = in_req_i.reference_id;
    job_o.strand      = in_req_i.reverse_strand;
    job_o.start       = in_req_i.align_start;
    job_o.ref_before  = re0;
    job_o.ref_end     = re_d;
    job_o.lclip_len   = (len < rlen) ? len : rlen;
    job_o.rclip_start = (len < rlen) ? (rlen - len) : '0;
    job_o.rclip_len   = rlen - job_o.rclip_start;
    job_o.q_begin     = qb_d;
    job_o.q_end       = qe_d;
    job_o.q_size      = qs_d;
  end

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~q_stat_i.full;
  assign push_o     = accept & (|job_o.ev);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_q <= '0;
      qb_q <= cbs_pkg::PosMax;
      qe_q <= '0;
      qs_q <= '0;
    end else if (accept) begin
      re_q <= re_d;
      qb_q <= qb_d;
      qe_q <= qe_d;
      qs_q <= qs_d;
    end
  end

endmodule

// ----- hdl/cbs_queue.sv -----
// Short job queue between the classifying front end and the result back end.
module cbs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cbs_pkg::job_t     job_i,
  input  logic              pop_i,
  output cbs_pkg::q_stat_t  stat_o,
  output cbs_pkg::job_t     head_o
);

  `include "cigar_breakpoint_scanner_unit_macros.svh"

  cbs_pkg::job_t               mem_q [cbs_pkg::QDepth];
  logic [cbs_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [cbs_pkg::QCntW-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  assign stat_o.full  = (cnt_q == cbs_pkg::QCntW'(cbs_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  `CBS_ASSERT_NEVER(a_q_overflow, clk_i, rst_ni, push_i && stat_o.full && !pop_i,
                    "job queue written while full")
  `CBS_ASSERT_NEVER(a_q_underflow, clk_i, rst_ni, pop_i && stat_o.empty,
                    "job queue popped while empty")

endmodule

// ----- hdl/cbs_back.sv -----
// Back end: expands each queued job into results, one per cycle unless stalled.
module cbs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbs_pkg::q_stat_t  q_stat_i,
  input  cbs_pkg::job_t     head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cbs_pkg::out_rsp_t out_rsp_o
);

  `include "cigar_breakpoint_scanner_unit_macros.svh"

  logic [cbs_pkg::NumEv-1:0] done_q, done_d, pending, sel, rest;
  logic                      out_valid_q, load;
  cbs_pkg::event_e           kind;
  cbs_pkg::out_rsp_t         rsp_d, rsp_q;

  // results leave in kind order: deletion, left clip, right clip, summary
  assign pending = head_i.ev & ~done_q;
  assign sel     = pending & (~pending + 1'b1);
  assign rest    = pending & ~sel;
  assign load    = ~q_stat_i.empty & (~out_valid_q | ~out_stall_i);
  assign pop_o   = load & (rest == '0);

  always_comb begin
    priority if (pending[cbs_pkg::EV_DEL])   kind = cbs_pkg::EV_DEL;
    else if (pending[cbs_pkg::EV_LCLIP])     kind = cbs_pkg::EV_LCLIP;
    else if (pending[cbs_pkg::EV_RCLIP])     kind = cbs_pkg::EV_RCLIP;
    else                                     kind = cbs_pkg::EV_SUM;
  end

  always_comb begin
    rsp_d = '0;
    rsp_d.event_kind     = kind;
    rsp_d.ref_index      = head_i.rid;
    rsp_d.strand_reverse = head_i.strand;
    rsp_d.last_result    = (rest == '0);
    unique case (kind)
      cbs_pkg::EV_DEL: begin
        rsp_d.left_position  = head_i.ref_before;
        rsp_d.right_position = head_i.ref_end;
      end
      cbs_pkg::EV_LCLIP: begin
        rsp_d.left_position  = cbs_pkg::PosMax;
        rsp_d.right_position = head_i.start;
        rsp_d.clip_length    = head_i.lclip_len;
      end
      cbs_pkg::EV_RCLIP: begin
        // reference end before the op: zero stays zero
        rsp_d.left_position  = (head_i.ref_before == '0) ? '0 : head_i.ref_before - 1'b1;
        rsp_d.right_position = cbs_pkg::PosMax;
        rsp_d.clip_start     = head_i.rclip_start;
        rsp_d.clip_length    = head_i.rclip_len;
      end
      cbs_pkg::EV_SUM: begin
        rsp_d.left_position  = head_i.start;
        rsp_d.right_position = head_i.ref_end;
        rsp_d.reference_end  = head_i.ref_end;
        rsp_d.query_start    = head_i.q_begin;
        rsp_d.query_stop     = head_i.q_end;
        rsp_d.query_total    = head_i.q_size;
      end
      default: ;
    endcase
  end

  always_comb begin
    done_d = done_q;
    if (load) done_d = (rest == '0) ? '0 : (done_q | sel);
  end

  always_ff @(posedge clk_i) begin
    if (load) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      done_q <= done_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  `CBS_ASSERT(a_done_holds, clk_i, rst_ni, (out_valid_q && out_stall_i) |=> $stable(done_q),
              "result progress moved while output stalled")
  `CBS_ASSERT(a_head_pending, clk_i, rst_ni, !q_stat_i.empty |-> (pending != '0),
              "queued job has no result left to send")

endmodule

// ----- hdl/cigar_breakpoint_scanner_unit.sv -----
// CIGAR breakpoint scanner top level: front end, job queue and result back end.
//
// Input channel: one CIGAR op per request (in_valid_i / in_stall_o, payload
// in_req_i) with its record fields; first_op restarts the record
// accumulators, last_op asks for the alignment summary.
// Output channel: results on out_valid_o / out_stall_i, payload out_rsp_o;
// last_result marks the final result caused by one op.
// Config: cfg_we_i writes register cfg_index_i (0 indel enable, 1 clip
// enable, 2 minimum deletion, 3 minimum clip) with cfg_wdata_i.
// Timing: an accepted op is written into the job queue at the accepting
// edge; the output register then loads its first result from the queue head
// once the back end is free to take it.
// Throughput: one op per cycle while the job queue is not full; an op owing
// several results (up to three) holds the result stage until all have left, and
// the four-entry job queue absorbs it. Ops owing no result never enter the queue.
// Reset: accumulators clear, registers take their defaults, the queue empties.
// When the receiver stalls, the output register holds; input stall rises only
// once the job queue is full.
module cigar_breakpoint_scanner_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cbs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cbs_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cbs_pkg::in_req_t             in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cbs_pkg::out_rsp_t            out_rsp_o
);

  cbs_pkg::q_stat_t q_stat;
  cbs_pkg::job_t    push_job, head_job;
  logic             push, pop;

  cbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  cbs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .stat_o (q_stat),
    .head_o (head_job)
  );

  cbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
